### hw/rtl/bced_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button click event detector package
// Types, codes and constants shared by the detector and its testbench.
// ----------------------------------------------------------------------------
package bced_pkg;

    localparam int BUTTONS_DEF = 8;

    // Reset values of the configuration registers.
    localparam logic [7:0]  ENABLE_RST = 8'd0;
    localparam logic        LEVEL_RST  = 1'b0;
    localparam logic [15:0] FILTER_RST = 16'd10;
    localparam logic [15:0] WINDOW_RST = 16'd300;

    // Configuration register indexes.
    localparam logic [1:0] REG_ENABLE = 2'd0;
    localparam logic [1:0] REG_LEVEL  = 2'd1;
    localparam logic [1:0] REG_FILTER = 2'd2;
    localparam logic [1:0] REG_WINDOW = 2'd3;

    // Input item actions.
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_SCAN = 1'b1;

    // Milliseconds per second and a reciprocal for dividing a 16-bit timer by it.
    localparam logic [15:0] MS_PER_SEC = 16'd1000;
    localparam logic [16:0] SEC_RECIP  = 17'd67109;
    localparam int          SEC_SHIFT  = 26;

    localparam logic [2:0] SETTLE_LAST = 3'd7;
    localparam logic [1:0] CLICKS_MAX  = 2'd3;

    typedef enum logic [1:0] {
        EV_DOWN   = 2'd0,
        EV_UP     = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_SECOND = 2'd3
    } t_ev_kind;

    typedef enum logic [2:0] {
        BS_RELEASED = 3'd0,
        BS_FILTER   = 3'd1,
        BS_START    = 3'd2,
        BS_TIMING   = 3'd3,
        BS_OVER     = 3'd4,
        BS_WAIT     = 3'd5
    } t_btn_state;

    typedef enum logic [2:0] {
        C_IDLE,
        C_TICK,
        C_LOAD,
        C_STEP,
        C_FINISH,
        C_OUT
    } t_ctl_state;

    // One RAM entry: everything the detector keeps for one button.
    typedef struct packed {
        logic [2:0]  st;
        logic [15:0] press_timer;
        logic [15:0] gap_timer;
        logic [6:0]  secs_rep;
        logic [1:0]  clicks;
    } t_entry;

endpackage

### hw/rtl/bced_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button click event detector channels
// Valid/ready channels for input items, event items and register writes.
// ----------------------------------------------------------------------------
interface bced_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [2:0] button_index;
    logic       level;
    logic [7:0] tick_ms;

    modport source (output valid, action, button_index, level, tick_ms, input ready);
    modport sink   (input valid, action, button_index, level, tick_ms, output ready);
endinterface

interface bced_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_button;
    logic [1:0]  event_kind;
    logic [15:0] event_value;
    logic        last;

    modport source (output valid, event_button, event_kind, event_value, last,
                    input ready);
    modport sink   (input valid, event_button, event_kind, event_value, last,
                    output ready);
endinterface

interface bced_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/button_click_event_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button click event detector
// Debounce, press timing, whole-second hold and double click for up to
// BUTTONS buttons, with per-button state kept in one RAM and valid bits in registers.
// ----------------------------------------------------------------------------
// A tick item reads, updates and writes back one RAM entry per cycle, the read
// of the next entry overlapping the write. A scan item is read, loaded, stepped
// one state machine step per cycle until it settles or SETTLE_LAST is reached,
// written back, and its event items go out one per cycle while o_event.ready is high.
// One item is in work at a time. Reset clears per-entry valid bits, so every
// button reads as released with zero timers at once; no clearing pass.
module button_click_event_detector #(
    parameter int BUTTONS = bced_pkg::BUTTONS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bced_in_if.sink    i_item,
    bced_out_if.source o_event,
    bced_cfg_if.sink   i_cfg
);

    localparam int AW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
    localparam int EW = $bits(bced_pkg::t_entry);
    localparam logic [AW-1:0] ADDR_LAST = AW'(BUTTONS - 1);

    // Configuration registers.
    logic [7:0]  r_en_mask;
    logic        r_press_level;
    logic [15:0] r_filter;
    logic [15:0] r_window;

    bced_pkg::t_ctl_state r_ctl, n_ctl;

    // Work registers of the item in progress.
    logic [AW-1:0]          r_addr;
    logic [2:0]             r_btn;
    logic [7:0]             r_tick;
    logic                   r_pressed;
    bced_pkg::t_btn_state   r_st;
    logic [15:0]            r_pt;
    logic [15:0]            r_gap;
    logic [6:0]             r_sec;
    logic [1:0]             r_cc;
    logic [6:0]             r_secs;
    logic [2:0]             r_iter;
    logic [1:0]             r_n;
    logic                   r_oidx;
    bced_pkg::t_ev_kind     r_ev_kind [2];
    logic [15:0]            r_ev_val  [2];

    logic [BUTTONS-1:0]     r_vld;
    logic                   r_rd_vld;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [AW-1:0]          ram_raddr;
    bced_pkg::t_entry       ram_wdata;
    logic [EW-1:0]          ram_q;
    bced_pkg::t_entry       rd_entry;
    logic [32:0]            rd_prod;

    logic                   in_acc;
    logic                   out_acc;
    logic                   scan_ok;
    logic                   out_last;

    // One step of the button state machine.
    bced_pkg::t_btn_state   s_st;
    logic [15:0]            s_pt;
    logic [6:0]             s_sec;
    logic [1:0]             s_cc;
    logic [15:0]            s_gap;
    logic [6:0]             s_secs;
    logic                   s_push;
    bced_pkg::t_ev_kind     s_kind;
    logic [15:0]            s_val;
    logic                   step_done;

    // Double click check after the state has settled.
    logic [1:0]             f_cc;
    logic                   f_push;

    assign in_acc  = i_item.valid & i_item.ready;
    assign out_acc = o_event.valid & o_event.ready;
    assign scan_ok = (32'(i_item.button_index) < BUTTONS) &&
                     r_en_mask[i_item.button_index];
    assign out_last = ({1'b0, r_oidx} == (r_n - 2'd1));

    assign rd_entry = r_rd_vld ? bced_pkg::t_entry'(ram_q) : '0;
    assign rd_prod  = 33'(rd_entry.press_timer) * 33'(bced_pkg::SEC_RECIP);

    bced_ram #(
        .WIDTH (EW),
        .DEPTH (BUTTONS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // Configuration port.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en_mask     <= bced_pkg::ENABLE_RST;
            r_press_level <= bced_pkg::LEVEL_RST;
            r_filter      <= bced_pkg::FILTER_RST;
            r_window      <= bced_pkg::WINDOW_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                bced_pkg::REG_ENABLE: r_en_mask     <= i_cfg.data[7:0];
                bced_pkg::REG_LEVEL:  r_press_level <= i_cfg.data[0];
                bced_pkg::REG_FILTER: r_filter      <= i_cfg.data;
                bced_pkg::REG_WINDOW: r_window      <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        s_st   = r_st;
        s_pt   = r_pt;
        s_sec  = r_sec;
        s_cc   = r_cc;
        s_gap  = r_gap;
        s_secs = r_secs;
        s_push = 1'b0;
        s_kind = bced_pkg::EV_DOWN;
        s_val  = r_pt;
        case (r_st)
            bced_pkg::BS_FILTER: begin
                if (r_pt >= r_filter) begin
                    s_st = r_pressed ? bced_pkg::BS_START : bced_pkg::BS_RELEASED;
                end
            end
            bced_pkg::BS_START: begin
                s_push = 1'b1;
                if (r_pressed) begin
                    s_pt   = '0;
                    s_sec  = '0;
                    s_secs = '0;
                    s_kind = bced_pkg::EV_DOWN;
                    s_val  = '0;
                    s_st   = bced_pkg::BS_TIMING;
                end else begin
                    s_kind = bced_pkg::EV_UP;
                    s_st   = bced_pkg::BS_RELEASED;
                end
            end
            bced_pkg::BS_TIMING: begin
                if (r_pressed) begin
                    if (r_secs != r_sec) begin
                        s_sec  = r_secs;
                        s_push = 1'b1;
                        s_kind = bced_pkg::EV_SECOND;
                        s_val  = 16'(16'(r_secs) * bced_pkg::MS_PER_SEC);
                    end
                end else begin
                    s_push = 1'b1;
                    s_kind = bced_pkg::EV_UP;
                    s_st   = bced_pkg::BS_OVER;
                end
            end
            bced_pkg::BS_OVER: begin
                if (r_cc < bced_pkg::CLICKS_MAX) begin
                    s_cc = r_cc + 2'd1;
                end
                if (s_cc == 2'd1) begin
                    s_gap = '0;
                end
                s_st = bced_pkg::BS_WAIT;
            end
            bced_pkg::BS_WAIT: begin
                if (!r_pressed) begin
                    s_st = bced_pkg::BS_RELEASED;
                end
            end
            default: begin
                // Released, and the two unused codes, which behave the same.
                if (r_pressed) begin
                    s_pt   = '0;
                    s_sec  = '0;
                    s_secs = '0;
                    s_st   = bced_pkg::BS_FILTER;
                end else begin
                    s_st   = bced_pkg::BS_RELEASED;
                end
            end
        endcase
    end

    assign step_done = (s_st == r_st) || (r_iter == bced_pkg::SETTLE_LAST);

    always_comb begin
        f_cc   = r_cc;
        f_push = 1'b0;
        if (r_cc == 2'd1 && r_gap >= r_window) begin
            f_cc = '0;
        end else if (r_cc >= 2'd2) begin
            f_cc   = '0;
            f_push = (r_n < 2'd2);
        end
    end

    // Next state.
    always_comb begin
        n_ctl = r_ctl;
        case (r_ctl)
            bced_pkg::C_IDLE: begin
                if (in_acc) begin
                    if (i_item.action == bced_pkg::ACT_TICK) begin
                        n_ctl = bced_pkg::C_TICK;
                    end else if (scan_ok) begin
                        n_ctl = bced_pkg::C_LOAD;
                    end
                end
            end
            bced_pkg::C_TICK: begin
                if (r_addr == ADDR_LAST) begin
                    n_ctl = bced_pkg::C_IDLE;
                end
            end
            bced_pkg::C_LOAD: n_ctl = bced_pkg::C_STEP;
            bced_pkg::C_STEP: begin
                if (step_done) begin
                    n_ctl = bced_pkg::C_FINISH;
                end
            end
            bced_pkg::C_FINISH: begin
                n_ctl = (r_n != 2'd0 || f_push) ? bced_pkg::C_OUT : bced_pkg::C_IDLE;
            end
            bced_pkg::C_OUT: begin
                if (out_acc && out_last) begin
                    n_ctl = bced_pkg::C_IDLE;
                end
            end
            default: n_ctl = bced_pkg::C_IDLE;
        endcase
    end

    // Outputs and RAM control.
    always_comb begin
        i_item.ready  = 1'b0;
        o_event.valid = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = r_addr;
        ram_raddr     = '0;
        ram_wdata     = rd_entry;
        case (r_ctl)
            bced_pkg::C_IDLE: begin
                i_item.ready = 1'b1;
                if (i_item.action == bced_pkg::ACT_SCAN && scan_ok) begin
                    ram_raddr = AW'(i_item.button_index);
                end
            end
            bced_pkg::C_TICK: begin
                ram_we                = 1'b1;
                ram_wdata.press_timer = rd_entry.press_timer + 16'(r_tick);
                ram_wdata.gap_timer   = rd_entry.gap_timer + 16'(r_tick);
                if (r_addr != ADDR_LAST) begin
                    ram_raddr = r_addr + 1'b1;
                end
            end
            bced_pkg::C_FINISH: begin
                ram_we    = 1'b1;
                ram_wdata = '{st: r_st, press_timer: r_pt, gap_timer: r_gap,
                              secs_rep: r_sec, clicks: f_cc};
            end
            bced_pkg::C_OUT: begin
                o_event.valid = 1'b1;
            end
            default: ;
        endcase
    end

    assign o_event.event_button = r_btn;
    assign o_event.event_kind   = r_ev_kind[r_oidx];
    assign o_event.event_value  = r_ev_val[r_oidx];
    assign o_event.last         = out_last;

    // Control state and valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= bced_pkg::C_IDLE;
            r_vld <= '0;
        end else begin
            r_ctl <= n_ctl;
            if (ram_we) begin
                r_vld[ram_waddr] <= 1'b1;
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_vld[ram_raddr];
        case (r_ctl)
            bced_pkg::C_IDLE: begin
                r_addr    <= (i_item.action == bced_pkg::ACT_SCAN) ?
                             AW'(i_item.button_index) : '0;
                r_tick    <= i_item.tick_ms;
                r_btn     <= i_item.button_index;
                r_pressed <= (i_item.level == r_press_level);
                r_n       <= '0;
                r_oidx    <= 1'b0;
            end
            bced_pkg::C_TICK: begin
                r_addr <= r_addr + 1'b1;
            end
            bced_pkg::C_LOAD: begin
                r_st   <= bced_pkg::t_btn_state'(rd_entry.st);
                r_pt   <= rd_entry.press_timer;
                r_gap  <= rd_entry.gap_timer;
                r_sec  <= rd_entry.secs_rep;
                r_cc   <= rd_entry.clicks;
                r_secs <= rd_prod[bced_pkg::SEC_SHIFT +: 7];
                r_iter <= '0;
            end
            bced_pkg::C_STEP: begin
                r_st   <= s_st;
                r_pt   <= s_pt;
                r_gap  <= s_gap;
                r_sec  <= s_sec;
                r_cc   <= s_cc;
                r_secs <= s_secs;
                r_iter <= r_iter + 3'd1;
                if (s_push && r_n < 2'd2) begin
                    r_ev_kind[r_n[0]] <= s_kind;
                    r_ev_val[r_n[0]]  <= s_val;
                    r_n               <= r_n + 2'd1;
                end
            end
            bced_pkg::C_FINISH: begin
                if (f_push) begin
                    r_ev_kind[r_n[0]] <= bced_pkg::EV_DOUBLE;
                    r_ev_val[r_n[0]]  <= r_pt;
                    r_n               <= r_n + 2'd1;
                end
            end
            bced_pkg::C_OUT: begin
                if (out_acc) begin
                    r_oidx <= 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

### hw/rtl/bced_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bced_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### test/button_click_event_detector_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button click event detector testbench
// Drives tick and scan items through the item channel, keeps its own model of
// every button's debounce, timing and click state, and checks each event item
// field by field under several register settings and random flow control.
// ----------------------------------------------------------------------------
module button_click_event_detector_tb;
    import bced_pkg::*;

    localparam int NUM_BUTTONS   = 8;
    localparam int SETTLE_STEPS  = 8;
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        logic [2:0]  button;
        t_ev_kind    kind;
        logic [15:0] value;
        logic        last;
    } click_event_t;

    // Per-button model of the detector plus the queue of events still owed.
    class click_scoreboard;
        t_btn_state   fsm[NUM_BUTTONS];
        logic [15:0]  press_ms[NUM_BUTTONS];
        logic [15:0]  gap_ms[NUM_BUTTONS];
        logic [6:0]   secs_seen[NUM_BUTTONS];
        logic [1:0]   clicks[NUM_BUTTONS];
        logic [7:0]   enable_mask;
        logic         press_lvl;
        logic [15:0]  filter_ms;
        logic [15:0]  window_ms;
        click_event_t owed_events[$];
        int           errors;
        int           kind_count[4];

        function new();
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                fsm[i]       = BS_RELEASED;
                press_ms[i]  = '0;
                gap_ms[i]    = '0;
                secs_seen[i] = '0;
                clicks[i]    = '0;
            end
            enable_mask = ENABLE_RST;
            press_lvl   = LEVEL_RST;
            filter_ms   = FILTER_RST;
            window_ms   = WINDOW_RST;
            errors      = 0;
            for (int k = 0; k < 4; k++) kind_count[k] = 0;
        endfunction

        function void write_reg(input logic [1:0] idx, input logic [15:0] wdata);
            case (idx)
                REG_ENABLE: enable_mask = wdata[7:0];
                REG_LEVEL:  press_lvl   = wdata[0];
                REG_FILTER: filter_ms   = wdata;
                REG_WINDOW: window_ms   = wdata;
                default: ;
            endcase
        endfunction

        function int pending();
            return owed_events.size();
        endfunction

        // Runs one accepted item; returns 0 when the item is a scan that the
        // block simply ignores.
        function bit note_item(input logic act, input logic [2:0] b, input logic lvl,
                               input logic [7:0] tick);
            click_event_t found[$];
            t_btn_state   cur;
            t_btn_state   nxt;
            logic         pressed;
            logic [6:0]   secs;
            logic [15:0]  held_value;
            if (act == ACT_TICK) begin
                for (int i = 0; i < NUM_BUTTONS; i++) begin
                    press_ms[i] = press_ms[i] + {8'd0, tick};
                    gap_ms[i]   = gap_ms[i] + {8'd0, tick};
                end
                return 1'b1;
            end
            if (!enable_mask[b])
                return 1'b0;

            pressed = (lvl == press_lvl);
            cur = fsm[b];
            for (int step = 0; step < SETTLE_STEPS; step++) begin
                nxt = cur;
                case (cur)
                    BS_FILTER: begin
                        if (press_ms[b] >= filter_ms)
                            nxt = pressed ? BS_START : BS_RELEASED;
                    end
                    BS_START: begin
                        if (pressed) begin
                            press_ms[b]  = '0;
                            secs_seen[b] = '0;
                            found.push_back('{b, EV_DOWN, press_ms[b], 1'b0});
                            nxt = BS_TIMING;
                        end else begin
                            found.push_back('{b, EV_UP, press_ms[b], 1'b0});
                            nxt = BS_RELEASED;
                        end
                    end
                    BS_TIMING: begin
                        if (pressed) begin
                            secs = 7'(press_ms[b] / MS_PER_SEC);
                            if (secs != secs_seen[b]) begin
                                secs_seen[b] = secs;
                                held_value = {9'd0, secs} * MS_PER_SEC;
                                found.push_back('{b, EV_SECOND, held_value, 1'b0});
                            end
                        end else begin
                            found.push_back('{b, EV_UP, press_ms[b], 1'b0});
                            nxt = BS_OVER;
                        end
                    end
                    BS_OVER: begin
                        if (clicks[b] < CLICKS_MAX)
                            clicks[b] = clicks[b] + 2'd1;
                        if (clicks[b] == 2'd1)
                            gap_ms[b] = '0;
                        nxt = BS_WAIT;
                    end
                    BS_WAIT: begin
                        if (!pressed)
                            nxt = BS_RELEASED;
                    end
                    default: begin
                        if (pressed) begin
                            press_ms[b]  = '0;
                            secs_seen[b] = '0;
                            nxt = BS_FILTER;
                        end else begin
                            nxt = BS_RELEASED;
                        end
                    end
                endcase
                if (nxt == cur)
                    break;
                cur = nxt;
            end
            fsm[b] = cur;

            // A lone first click expires once the gap reaches the window.
            if (clicks[b] == 2'd1 && gap_ms[b] >= window_ms) begin
                clicks[b] = '0;
            end else if (clicks[b] >= 2'd2) begin
                clicks[b] = '0;
                if (found.size() < 2)
                    found.push_back('{b, EV_DOUBLE, press_ms[b], 1'b0});
            end

            if (found.size() > 0)
                found[found.size() - 1].last = 1'b1;
            foreach (found[i]) owed_events.push_back(found[i]);
            return 1'b1;
        endfunction

        function void check_event(input logic [2:0] btn, input logic [1:0] kind,
                                  input logic [15:0] value, input logic last_flag);
            click_event_t want;
            if (owed_events.size() == 0) begin
                $display("%0t: event with none expected: button %0d kind %0d value %0d last %0b",
                         $time, btn, kind, value, last_flag);
                errors++;
                return;
            end
            want = owed_events.pop_front();
            if (btn !== want.button) begin
                $display("%0t: event_button expected %0d actual %0d", $time, want.button, btn);
                errors++;
            end
            if (kind !== want.kind) begin
                $display("%0t: event_kind expected %0d actual %0d", $time, want.kind, kind);
                errors++;
            end
            if (value !== want.value) begin
                $display("%0t: event_value expected %0d actual %0d", $time, want.value, value);
                errors++;
            end
            if (last_flag !== want.last) begin
                $display("%0t: last expected %0b actual %0b", $time, want.last, last_flag);
                errors++;
            end
            kind_count[want.kind]++;
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    bced_in_if  item_if();
    bced_out_if event_if();
    bced_cfg_if cfg_if();

    click_scoreboard sb = new();

    bit steady_tx = 1'b0;
    bit steady_rx = 1'b0;
    int items_done = 0;
    int settings_run = 0;

    button_click_event_detector u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .o_event (event_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("button_click_event_detector_tb NOT OK");
        $finish;
    end

    // Mostly short waits, now and then a long one.
    function automatic int stall_len();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int pick_gap();
        if (steady_tx || $urandom_range(0, 99) < 55)
            return 0;
        return stall_len();
    endfunction

    function automatic logic [7:0] pick_tick();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 8'($urandom_range(0, 40));
        if (r < 95)
            return 8'($urandom_range(41, 150));
        return 8'($urandom_range(151, 255));
    endfunction

    // Event sink: checks each accepted event item, then picks the next ready.
    initial begin : event_sink
        int stall;
        stall = 0;
        event_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && event_if.valid && event_if.ready)
                sb.check_event(event_if.event_button, event_if.event_kind,
                               event_if.event_value, event_if.last);
            if (stall > 0) begin
                event_if.ready <= 1'b0;
                stall--;
            end else if (!steady_rx && $urandom_range(0, 99) < 15) begin
                event_if.ready <= 1'b0;
                stall = stall_len() - 1;
            end else begin
                event_if.ready <= 1'b1;
            end
        end
    end

    // Valid stays high from one item to the next when there is no gap.
    task automatic send_item(input logic act, input logic [2:0] b, input logic lvl,
                             input logic [7:0] tick);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_if.valid        <= 1'b1;
        item_if.action       <= act;
        item_if.button_index <= b;
        item_if.level        <= lvl;
        item_if.tick_ms      <= tick;
        do @(posedge i_clk); while (!item_if.ready);
        if (sb.note_item(act, b, lvl, tick))
            items_done++;
    endtask

    task automatic advance(input logic [7:0] ms);
        send_item(ACT_TICK, 3'($urandom), 1'($urandom), ms);
    endtask

    task automatic scan(input logic [2:0] b, input logic lvl);
        send_item(ACT_SCAN, b, lvl, 8'($urandom));
    endtask

    task automatic wait_idle();
        item_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [1:0] idx, input logic [15:0] wdata);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= wdata;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.write_reg(idx, wdata);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // One press: optional contact bounce, a hold of about hold_ms with scans
    // along the way, then the release.
    task automatic click_press(input logic [2:0] b, input int hold_ms);
        logic p;
        int   held;
        logic [7:0] t;
        p = sb.press_lvl;
        held = 0;
        if ($urandom_range(0, 9) < 3) begin
            repeat ($urandom_range(1, 3)) begin
                scan(b, p);
                advance(8'($urandom_range(0, 4)));
                scan(b, ~p);
            end
        end
        scan(b, p);
        while (held < hold_ms) begin
            t = pick_tick();
            advance(t);
            held += t;
            if ($urandom_range(0, 1) == 1)
                scan(b, p);
        end
        scan(b, ~p);
    endtask

    task automatic button_gesture();
        logic [2:0] b;
        int gap;
        int waited;
        logic [7:0] t;
        if (sb.enable_mask == 8'd0 || $urandom_range(0, 9) == 0) begin
            b = 3'($urandom_range(0, 7));
        end else begin
            do b = 3'($urandom_range(0, 7)); while (!sb.enable_mask[b]);
        end
        if ($urandom_range(0, 99) < 75)
            click_press(b, $urandom_range(20, 700));
        else
            click_press(b, $urandom_range(900, 3500));
        // Second click, sometimes inside the double-click window.
        if ($urandom_range(0, 9) < 4) begin
            gap = $urandom_range(0, 600);
            waited = 0;
            while (waited < gap) begin
                t = pick_tick();
                advance(t);
                waited += t;
            end
            click_press(b, $urandom_range(20, 400));
        end
    endtask

    task automatic noise_item();
        if ($urandom_range(0, 1) == 0)
            advance(8'($urandom_range(0, 255)));
        else
            scan(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
    endtask

    // Holds one button long enough for its press timer to wrap.
    task automatic hold_through_wrap(input logic [2:0] b);
        logic p;
        p = sb.press_lvl;
        scan(b, p);
        for (int i = 0; i < 280; i++) begin
            advance(8'd255);
            if (i % 8 == 0)
                scan(b, p);
        end
        scan(b, ~p);
    endtask

    task automatic run_directed();
        set_reg(REG_ENABLE, 16'h0000);
        scan(3'd3, 1'b1);
        wait_idle();
        set_reg(REG_ENABLE, 16'h00FF);
        set_reg(REG_LEVEL, 16'h0001);
        set_reg(REG_FILTER, 16'd10);
        set_reg(REG_WINDOW, 16'd300);
        settings_run++;
        advance(8'd0);
        scan(3'd7, 1'b1);
        advance(8'd255);
        scan(3'd7, 1'b1);
        repeat (4) advance(8'd255);
        scan(3'd7, 1'b1);
        scan(3'd7, 1'b0);
        // Quick second click gives up and double click from one scan.
        scan(3'd7, 1'b1);
        advance(8'd20);
        scan(3'd7, 1'b1);
        advance(8'd50);
        scan(3'd7, 1'b0);
        // A blip shorter than the filter time settles back to released.
        scan(3'd0, 1'b1);
        advance(8'd5);
        scan(3'd0, 1'b0);
        advance(8'd10);
        scan(3'd0, 1'b0);
        scan(3'd0, 1'b0);
    endtask

    task automatic run_phase(input logic [7:0] mask, input logic lvl,
                             input logic [15:0] filter, input logic [15:0] window,
                             input int count, input bit with_wrap, input bit with_pause);
        int  start;
        bit  paused;
        wait_idle();
        set_reg(REG_ENABLE, {8'd0, mask});
        set_reg(REG_LEVEL, {15'd0, lvl});
        set_reg(REG_FILTER, filter);
        set_reg(REG_WINDOW, window);
        settings_run++;
        start = items_done;
        paused = 1'b0;
        if (with_wrap)
            hold_through_wrap(3'($urandom_range(0, 7)));
        while (items_done - start < count) begin
            steady_tx = ($urandom_range(0, 4) == 0);
            steady_rx = ($urandom_range(0, 4) == 0);
            if (with_pause && !paused && items_done - start > count / 2) begin
                wait_idle();
                paused = 1'b1;
            end
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 6)) noise_item();
            else
                button_gesture();
        end
        steady_tx = 1'b0;
        steady_rx = 1'b0;
    endtask

    initial begin
        i_rst_n              <= 1'b0;
        item_if.valid        <= 1'b0;
        item_if.action       <= ACT_TICK;
        item_if.button_index <= '0;
        item_if.level        <= 1'b0;
        item_if.tick_ms      <= '0;
        cfg_if.valid         <= 1'b0;
        cfg_if.index         <= REG_ENABLE;
        cfg_if.data          <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        run_phase(8'hFF, 1'b0, 16'd10, 16'd300, 160, 1'b0, 1'b0);
        run_phase(8'hA5, 1'b1, 16'd0, 16'd0, 160, 1'b0, 1'b0);
        run_phase(8'hFF, 1'b1, 16'hFFFF, 16'hFFFF, 60, 1'b0, 1'b0);
        run_phase(8'h5A, 1'b0, 16'($urandom_range(0, 200)), 16'($urandom_range(100, 800)),
                  170, 1'b0, 1'b1);
        run_phase(8'hFF, 1'b1, 16'd20, 16'd400, 150, 1'b1, 1'b0);
        run_phase(8'h01 | 8'($urandom), 1'($urandom), 16'($urandom_range(0, 100)),
                  16'($urandom_range(0, 1000)), 150, 1'b0, 1'b0);
        run_phase(8'hFF, 1'b0, 16'd0, 16'hFFFF, 160, 1'b0, 1'b0);
        run_phase(8'h80 | 8'($urandom), 1'($urandom), 16'($urandom_range(0, 60)),
                  16'($urandom_range(150, 700)), 150, 1'b0, 1'b0);
        wait_idle();

        $display("Checked %0d down, %0d up, %0d double-click and %0d held-second events",
                 sb.kind_count[EV_DOWN], sb.kind_count[EV_UP],
                 sb.kind_count[EV_DOUBLE], sb.kind_count[EV_SECOND]);
        $display("from %0d items over %0d register settings, including a press held past wrap.",
                 items_done, settings_run);
        if (sb.errors == 0) begin
            $display("button_click_event_detector_tb OK");
        end else begin
            $display("button_click_event_detector_tb NOT OK");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/bced_pkg.sv
hw/rtl/bced_if.sv
hw/rtl/bced_ram.sv
hw/rtl/button_click_event_detector.sv
test/button_click_event_detector_tb.sv
